>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CBCS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cbcs assertion failed");
`define CBCS_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("cbcs assertion failed");
`else
`define CBCS_ASSERT(label, clk, rst, prop)
`define CBCS_ASSERT_NORST(label, clk, prop)
`endif
`endif

>>> hdl/cbcs_pkg.sv
// ----------------------------------------------------------------------------
// cbcs_pkg
// Types and constants of the camera bus command sender.
// ----------------------------------------------------------------------------
package cbcs_pkg;

   localparam int FrameBytesDefault = 8;
   localparam int SendBytesDefault  = 2;

   localparam int BitTicksW    = 10;
   localparam int SyncTicksW   = 16;
   localparam int RepeatW      = 4;
   localparam int CsrIndexW    = 2;
   localparam int CsrDataW     = 16;
   localparam int ReqDataW     = 24;
   localparam int RspDataW     = 16;

   localparam logic [BitTicksW-1:0]  BitTicksReset    = 10'd104;
   localparam logic [SyncTicksW-1:0] SyncTicksReset   = 16'd5000;
   localparam logic [RepeatW-1:0]    RepeatLimitReset = 4'd5;
   localparam logic [2:0]            StatusByteIndex  = 3'd5;
   localparam logic [7:0]            StatusClear      = 8'h00;

   typedef enum logic [CsrIndexW-1:0] {
      REG_BIT_TICKS    = 2'd0,
      REG_SYNC_TICKS   = 2'd1,
      REG_REPEAT_LIMIT = 2'd2,
      REG_LINK_PRESENT = 2'd3
   } reg_index_type;

   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_SYNC  = 5'b00010,
      PH_START = 5'b00100,
      PH_DATA  = 5'b01000,
      PH_GAP   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [BitTicksW-1:0]  bit_ticks;
      logic [SyncTicksW-1:0] sync_ticks;
      logic [RepeatW-1:0]    repeat_limit;
      logic                  link_present;
   } cfg_type;

   typedef struct packed {
      logic       refused;
      logic [3:0] frames_sent;
      logic [7:0] status_byte;
      logic       done_res;
      logic       busy_res;
      logic       drive_level;
   } result_type;

endpackage

>>> hdl/camera_bus_command_sender.sv
// ----------------------------------------------------------------------------
// camera_bus_command_sender
// Single-wire camera bus command sender, one bus tick per input transfer.
// ----------------------------------------------------------------------------
// Each req_ transfer is one bus tick: the sampled line level, and in req_tuser
// a start request that takes the mode and command bytes. After a start the
// block waits for a long high gap, then sends frames of FRAME_BYTES bytes,
// driving the first SEND_BYTES and sampling the reply bytes at mid-cell.
// Each rsp_ transfer is the result for one tick: the drive level, busy and
// status, the frame count and a refused flag; rsp_tlast marks the tick on
// which a command sequence finishes.
// Each req_ result is registered and shows on rsp_ in the cycle after its
// transfer. One tick is taken in every cycle unless the receiver stalls;
// the sequencer state and result register are each updated once per tick.
// When the receiver stalls, the result is held in the output register and
// req_tready falls until it is taken, so no tick is lost.
// Reset clears the sequencer to idle, empties the output register and loads
// the configuration registers with their default values.
// ----------------------------------------------------------------------------
module camera_bus_command_sender #(
   parameter int FRAME_BYTES = cbcs_pkg::FrameBytesDefault,
   parameter int SEND_BYTES  = cbcs_pkg::SendBytesDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // mode_byte [7:0], command_byte [15:8], line_level [16], zero fill
   input  logic [cbcs_pkg::ReqDataW-1:0]   req_tdata,
   // cmd [0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // drive_level [0], busy_res [1], status_byte [9:2], frames_sent [13:10],
   // refused [14], zero fill
   output logic [cbcs_pkg::RspDataW-1:0]   rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [cbcs_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [cbcs_pkg::CsrDataW-1:0]   csr_wdata
);
   import cbcs_pkg::*;

   cfg_type    cfg;
   result_type res;
   logic       advance;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0] rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   cbcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cbcs_engine #(
      .FRAME_BYTES (FRAME_BYTES),
      .SEND_BYTES  (SEND_BYTES)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .cmd          (req_tuser),
      .mode_byte    (req_tdata[7:0]),
      .command_byte (req_tdata[15:8]),
      .line_level   (req_tdata[16]),
      .cfg          (cfg),
      .res          (res)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign advance    = req_tvalid && req_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, res.refused, res.frames_sent, res.status_byte,
                         res.busy_res, res.drive_level};
         rsp_last_in  = res.done_res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> hdl/cbcs_csr.sv
// ----------------------------------------------------------------------------
// cbcs_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module cbcs_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [cbcs_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [cbcs_pkg::CsrDataW-1:0]   csr_wdata,
   output cbcs_pkg::cfg_type               cfg
);
   import cbcs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_BIT_TICKS:    cfg_in.bit_ticks    = csr_wdata[BitTicksW-1:0];
            REG_SYNC_TICKS:   cfg_in.sync_ticks   = csr_wdata[SyncTicksW-1:0];
            REG_REPEAT_LIMIT: cfg_in.repeat_limit = csr_wdata[RepeatW-1:0];
            REG_LINK_PRESENT: cfg_in.link_present = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_ticks    <= BitTicksReset;
         cfg_ff.sync_ticks   <= SyncTicksReset;
         cfg_ff.repeat_limit <= RepeatLimitReset;
         cfg_ff.link_present <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/cbcs_engine.sv
// ----------------------------------------------------------------------------
// cbcs_engine
// Bus sequencer: gap search, start and data cells, reply sampling and
// frame repetition, advanced by one tick per accepted transfer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module cbcs_engine #(
   parameter int FRAME_BYTES = cbcs_pkg::FrameBytesDefault,
   parameter int SEND_BYTES  = cbcs_pkg::SendBytesDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 cmd,
   input  logic [7:0]           mode_byte,
   input  logic [7:0]           command_byte,
   input  logic                 line_level,
   input  cbcs_pkg::cfg_type    cfg,
   output cbcs_pkg::result_type res
);
   import cbcs_pkg::*;

   localparam logic [3:0] SendCount  = 4'(SEND_BYTES);
   localparam logic [3:0] FrameCount = 4'(FRAME_BYTES);

   phase_type              phase_ff, phase_in;
   logic [BitTicksW-1:0]   tick_count_ff, tick_count_in;
   logic [SyncTicksW-1:0]  high_run_ff, high_run_in;
   logic [2:0]             bit_index_ff, bit_index_in;
   logic [2:0]             byte_index_ff, byte_index_in;
   logic [3:0]             attempts_ff, attempts_in;
   logic [7:0]             shift_reg_ff, shift_reg_in;
   logic [15:0]            send_bytes_ff, send_bytes_in;
   logic [7:0]             last_status_ff, last_status_in;

   logic [BitTicksW:0]     tick_inc;
   logic                   cell_done;
   logic                   one_tick_cell;
   logic                   sending;
   logic [7:0]             tx_bits;
   logic [3:0]             attempts_next;
   logic                   drive, done, refused;

   assign tick_inc      = {1'b0, tick_count_ff} + {{BitTicksW{1'b0}}, 1'b1};
   assign cell_done     = tick_inc >= {1'b0, cfg.bit_ticks};
   assign one_tick_cell = cfg.bit_ticks <= {{(BitTicksW-1){1'b0}}, 1'b1};
   assign sending       = {1'b0, byte_index_ff} < SendCount;
   assign attempts_next = attempts_ff + 4'd1;

   always_comb begin
      case (byte_index_ff)
         3'd0:    tx_bits = send_bytes_ff[7:0];
         3'd1:    tx_bits = send_bytes_ff[15:8];
         default: tx_bits = 8'h00;
      endcase
   end

   always_comb begin
      phase_in       = phase_ff;
      tick_count_in  = tick_count_ff;
      high_run_in    = high_run_ff;
      bit_index_in   = bit_index_ff;
      byte_index_in  = byte_index_ff;
      attempts_in    = attempts_ff;
      shift_reg_in   = shift_reg_ff;
      send_bytes_in  = send_bytes_ff;
      last_status_in = last_status_ff;
      drive          = 1'b0;
      done           = 1'b0;
      refused        = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (cmd) begin
               if (!cfg.link_present) begin
                  refused = 1'b1;
               end else begin
                  phase_in       = PH_SYNC;
                  high_run_in    = '0;
                  attempts_in    = '0;
                  byte_index_in  = '0;
                  bit_index_in   = '0;
                  tick_count_in  = '0;
                  shift_reg_in   = '0;
                  last_status_in = StatusClear;
                  send_bytes_in  = {command_byte, mode_byte};
               end
            end
         end
         PH_SYNC: begin
            refused = cmd;
            if (line_level) begin
               if (high_run_ff != '1) begin
                  high_run_in = high_run_ff + 16'd1;
               end
            end else if (high_run_ff >= cfg.sync_ticks) begin
               byte_index_in = '0;
               phase_in      = PH_START;
               tick_count_in = 10'd1;
               if (one_tick_cell) begin
                  phase_in      = PH_DATA;
                  tick_count_in = '0;
                  bit_index_in  = '0;
                  shift_reg_in  = '0;
               end
            end else begin
               high_run_in = '0;
            end
         end
         PH_START: begin
            refused       = cmd;
            tick_count_in = cell_done ? '0 : tick_inc[BitTicksW-1:0];
            if (cell_done) begin
               phase_in     = PH_DATA;
               bit_index_in = '0;
               shift_reg_in = '0;
            end
         end
         PH_DATA: begin
            refused = cmd;
            if (sending) begin
               drive = tx_bits[bit_index_ff];
            end else if (tick_count_ff == (cfg.bit_ticks >> 1)) begin
               shift_reg_in[bit_index_ff] = line_level;
            end
            tick_count_in = cell_done ? '0 : tick_inc[BitTicksW-1:0];
            if (cell_done) begin
               if (bit_index_ff == 3'd7) begin
                  if (!sending && byte_index_ff == StatusByteIndex) begin
                     last_status_in = shift_reg_in;
                  end
                  phase_in = PH_GAP;
               end else begin
                  bit_index_in = bit_index_ff + 3'd1;
               end
            end
         end
         PH_GAP: begin
            refused = cmd;
            if (!line_level) begin
               if ({1'b0, byte_index_ff} + 4'd1 >= FrameCount) begin
                  attempts_in = attempts_next;
                  if (!last_status_ff[0] || attempts_next >= cfg.repeat_limit) begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     byte_index_in = '0;
                     phase_in      = PH_START;
                     tick_count_in = 10'd1;
                     if (one_tick_cell) begin
                        phase_in      = PH_DATA;
                        tick_count_in = '0;
                        bit_index_in  = '0;
                        shift_reg_in  = '0;
                     end
                  end
               end else begin
                  byte_index_in = byte_index_ff + 3'd1;
                  phase_in      = PH_START;
                  tick_count_in = 10'd1;
                  if (one_tick_cell) begin
                     phase_in      = PH_DATA;
                     tick_count_in = '0;
                     bit_index_in  = '0;
                     shift_reg_in  = '0;
                  end
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
            refused  = cmd;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         tick_count_ff  <= '0;
         high_run_ff    <= '0;
         bit_index_ff   <= '0;
         byte_index_ff  <= '0;
         attempts_ff    <= '0;
         shift_reg_ff   <= '0;
         send_bytes_ff  <= '0;
         last_status_ff <= '0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         tick_count_ff  <= tick_count_in;
         high_run_ff    <= high_run_in;
         bit_index_ff   <= bit_index_in;
         byte_index_ff  <= byte_index_in;
         attempts_ff    <= attempts_in;
         shift_reg_ff   <= shift_reg_in;
         send_bytes_ff  <= send_bytes_in;
         last_status_ff <= last_status_in;
      end
   end

   assign res.drive_level = drive;
   assign res.busy_res    = phase_in != PH_IDLE;
   assign res.done_res    = done;
   assign res.status_byte = last_status_in;
   assign res.frames_sent = attempts_in;
   assign res.refused     = refused;

   `CBCS_ASSERT(a_done_not_busy, clock, reset, res.done_res |-> !res.busy_res)
   `CBCS_ASSERT(a_drive_only_in_data, clock, reset,
      phase_ff != PH_DATA |-> !res.drive_level)
   `CBCS_ASSERT(a_refused_stays_idle, clock, reset,
      advance && phase_ff == PH_IDLE && res.refused |=> phase_ff == PH_IDLE)

endmodule

>>> test/camera_bus_command_sender_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// camera_bus_command_sender_tb
// Self-checking bench for the single-wire camera bus command sender.
// ----------------------------------------------------------------------------
// Every req_ transfer is one bus tick. The bench keeps its own model of the
// sequencer and plays the bus device: it holds the line high for the frame
// gap, answers reply bytes and releases the line between bytes, with some
// noise and stray start requests mixed in. A short table of ticks covers
// reset, refused starts and the one-tick cell case, and random phases with
// random register settings follow. Each rsp_ transfer is checked field by
// field against the oldest predicted result.
// ----------------------------------------------------------------------------
module camera_bus_command_sender_tb;
   import cbcs_pkg::*;

   localparam int CycleLimit  = 10_000_000;
   localparam int TotalItems  = 1950;
   localparam int DrainCycles = 20;

   typedef struct packed {
      logic       cmd;
      logic [7:0] mode;
      logic [7:0] command;
      logic       line;
      logic       known;
      result_type res;
   } tick_row_type;

   // Field order: refused, frames_sent, status_byte, done_res, busy_res, drive_level.
   localparam result_type ResQuiet        = '{1'b0, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0};
   localparam result_type ResRefused      = '{1'b1, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0};
   localparam result_type ResBusy         = '{1'b0, 4'd0, 8'd0, 1'b0, 1'b1, 1'b0};
   localparam result_type ResRefusedBusy  = '{1'b1, 4'd0, 8'd0, 1'b0, 1'b1, 1'b0};

   // The first three rows run with the reset settings and no link; the rest
   // run with one-tick cells, no gap requirement and a single frame.
   localparam tick_row_type StartRows [0:12] = '{
      '{1'b0, 8'h00, 8'h00, 1'b0, 1'b1, ResQuiet},
      '{1'b1, 8'hFF, 8'hFF, 1'b1, 1'b1, ResRefused},
      '{1'b1, 8'h00, 8'h00, 1'b0, 1'b1, ResRefused},
      '{1'b1, 8'hA5, 8'h3C, 1'b1, 1'b1, ResBusy},
      '{1'b1, 8'h5A, 8'hC3, 1'b0, 1'b1, ResRefusedBusy},
      '{1'b0, 8'hFF, 8'h00, 1'b1, 1'b0, ResQuiet},
      '{1'b0, 8'h00, 8'hFF, 1'b0, 1'b0, ResQuiet},
      '{1'b0, 8'hFF, 8'h00, 1'b1, 1'b0, ResQuiet},
      '{1'b0, 8'h00, 8'hFF, 1'b0, 1'b0, ResQuiet},
      '{1'b0, 8'hFF, 8'h00, 1'b1, 1'b0, ResQuiet},
      '{1'b0, 8'h00, 8'hFF, 1'b0, 1'b0, ResQuiet},
      '{1'b0, 8'hFF, 8'h00, 1'b1, 1'b0, ResQuiet},
      '{1'b0, 8'h00, 8'hFF, 1'b0, 1'b0, ResQuiet}
   };

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [ReqDataW-1:0]  req_tdata  = '0;
   logic                 req_tuser  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RspDataW-1:0]  rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_we     = 1'b0;
   logic [CsrIndexW-1:0] csr_index  = '0;
   logic [CsrDataW-1:0]  csr_wdata  = '0;

   camera_bus_command_sender dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sequencer model state.
   cfg_type          bus_cfg      = '{BitTicksReset, SyncTicksReset, RepeatLimitReset, 1'b0};
   phase_type        seq_phase    = PH_IDLE;
   logic [15:0]      seq_ticks    = '0;
   logic [15:0]      seq_high_run = '0;
   logic [2:0]       seq_bit      = '0;
   logic [2:0]       seq_byte     = '0;
   logic [3:0]       seq_frames   = '0;
   logic [7:0]       seq_shift    = '0;
   logic [15:0]      seq_bytes    = '0;
   logic [7:0]       seq_status   = '0;

   result_type       pending_results [$];
   int               errors       = 0;
   int               cycles       = 0;
   int               rsp_hold     = 0;
   int               sent_count   = 0;
   bit               send_idle    = 1'b0;
   bit               rsp_idle     = 1'b0;
   bit               winding      = 1'b0;
   int               high_driven  = 0;
   int               gap_target   = 0;

   function automatic int pick_gap();
      return ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
   endfunction

   function automatic logic cell_tick();
      seq_ticks = seq_ticks + 16'd1;
      if (seq_ticks >= {6'd0, bus_cfg.bit_ticks}) begin
         seq_ticks = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void open_byte();
      seq_phase = PH_START;
      seq_ticks = '0;
      if (cell_tick()) begin
         seq_phase = PH_DATA;
         seq_bit   = '0;
         seq_shift = '0;
      end
   endfunction

   function automatic result_type advance_sequencer(input logic start, input logic [7:0] mode,
                                                    input logic [7:0] command, input logic line);
      logic       pend;
      logic       drive;
      logic       done;
      logic       refused;
      logic       sending;
      logic [7:0] tx;
      result_type r;
      pend    = start;
      drive   = 1'b0;
      done    = 1'b0;
      refused = 1'b0;
      sending = int'(seq_byte) < SendBytesDefault;
      tx = (seq_byte == 3'd0) ? seq_bytes[7:0] : (seq_byte == 3'd1) ? seq_bytes[15:8] : 8'h00;
      case (seq_phase)
         PH_IDLE: begin
            if (start) begin
               if (!bus_cfg.link_present) begin
                  refused = 1'b1;
               end else begin
                  seq_phase    = PH_SYNC;
                  seq_high_run = '0;
                  seq_frames   = '0;
                  seq_byte     = '0;
                  seq_bit      = '0;
                  seq_ticks    = '0;
                  seq_shift    = '0;
                  seq_status   = StatusClear;
                  seq_bytes    = {command, mode};
               end
            end
            pend = 1'b0;
         end
         PH_SYNC: begin
            if (line) begin
               if (seq_high_run != 16'hFFFF) seq_high_run = seq_high_run + 16'd1;
            end else if (seq_high_run >= bus_cfg.sync_ticks) begin
               seq_byte = '0;
               open_byte();
            end else begin
               seq_high_run = '0;
            end
         end
         PH_START: begin
            if (cell_tick()) begin
               seq_phase = PH_DATA;
               seq_bit   = '0;
               seq_shift = '0;
            end
         end
         PH_DATA: begin
            if (sending) begin
               drive = tx[seq_bit];
            end else if (seq_ticks == {7'd0, bus_cfg.bit_ticks[9:1]}) begin
               seq_shift[seq_bit] = line;
            end
            if (cell_tick()) begin
               if (seq_bit == 3'd7) begin
                  if (!sending && seq_byte == StatusByteIndex) seq_status = seq_shift;
                  seq_phase = PH_GAP;
               end else begin
                  seq_bit = seq_bit + 3'd1;
               end
            end
         end
         PH_GAP: begin
            if (!line) begin
               if (int'(seq_byte) + 1 >= FrameBytesDefault) begin
                  seq_frames = seq_frames + 4'd1;
                  if (!seq_status[0] || seq_frames >= bus_cfg.repeat_limit) begin
                     seq_phase = PH_IDLE;
                     done      = 1'b1;
                  end else begin
                     seq_byte = '0;
                     open_byte();
                  end
               end else begin
                  seq_byte = seq_byte + 3'd1;
                  open_byte();
               end
            end
         end
         default: begin
            seq_phase = PH_IDLE;
         end
      endcase
      if (pend) refused = 1'b1;
      r.drive_level = drive;
      r.busy_res    = (seq_phase != PH_IDLE);
      r.done_res    = done;
      r.status_byte = seq_status;
      r.frames_sent = seq_frames;
      r.refused     = refused;
      return r;
   endfunction

   task automatic send_tick(input logic cmd, input logic [7:0] mode, input logic [7:0] command,
                            input logic line, input logic known, input result_type typed);
      result_type exp;
      int         gap;
      if (cmd && seq_phase == PH_IDLE && bus_cfg.link_present) begin
         high_driven = 0;
         gap_target  = int'(bus_cfg.sync_ticks) + int'($urandom_range(0, 3));
      end
      if (seq_phase == PH_SYNC) high_driven = line ? high_driven + 1 : 0;
      exp = advance_sequencer(cmd, mode, command, line);
      if (known) exp = typed;
      gap = (send_idle && $urandom_range(0, 4) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'd0, line, command, mode};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(exp);
      sent_count++;
   endtask

   // Plays the device side: gap, reply bytes and line release between bytes.
   task automatic random_tick();
      logic cmd;
      logic line;
      if (winding) cmd = 1'b0;
      else if (seq_phase == PH_IDLE) cmd = ($urandom_range(0, 5) == 0);
      else cmd = ($urandom_range(0, 199) == 0);
      case (seq_phase)
         PH_SYNC: begin
            if (high_driven >= gap_target) line = 1'b0;
            else line = !(!winding && $urandom_range(0, 31) == 0);
         end
         PH_DATA: begin
            if (seq_byte == StatusByteIndex && seq_bit == 3'd0)
               line = winding ? 1'b0 : ($urandom_range(0, 3) != 0);
            else
               line = 1'($urandom_range(0, 1));
         end
         PH_GAP: begin
            line = winding ? 1'b0 : ($urandom_range(0, 2) == 0);
         end
         default: begin
            line = 1'($urandom_range(0, 1));
         end
      endcase
      send_tick(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), line, 1'b0,
                ResQuiet);
   endtask

   task automatic wind_down();
      winding = 1'b1;
      while (seq_phase != PH_IDLE) random_tick();
      winding = 1'b0;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic load_config(input cfg_type c);
      reg_index_type        order [4] = '{REG_BIT_TICKS, REG_SYNC_TICKS, REG_REPEAT_LIMIT,
                                          REG_LINK_PRESENT};
      logic [CsrDataW-1:0]  vals [4];
      vals[0] = {6'd0, c.bit_ticks};
      vals[1] = c.sync_ticks;
      vals[2] = {12'd0, c.repeat_limit};
      vals[3] = {15'd0, c.link_present};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we  <= 1'b0;
      bus_cfg = c;
   endtask

   function automatic void check_field(input string name, input int expv, input int actv);
      if (expv != actv) begin
         errors++;
         $display("%0t: %s expected %0d, got %0d", $time, name, expv, actv);
      end
   endfunction

   always @(posedge clock) begin : watch_results
      result_type exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: transfer with nothing expected, got data %h last %b",
                     $time, rsp_tdata, rsp_tlast);
         end else begin
            exp = pending_results.pop_front();
            check_field("drive_level", int'(exp.drive_level), int'(rsp_tdata[0]));
            check_field("busy_res", int'(exp.busy_res), int'(rsp_tdata[1]));
            check_field("status_byte", int'(exp.status_byte), int'(rsp_tdata[9:2]));
            check_field("frames_sent", int'(exp.frames_sent), int'(rsp_tdata[13:10]));
            check_field("refused", int'(exp.refused), int'(rsp_tdata[14]));
            check_field("done_res", int'(exp.done_res), int'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_idle && $urandom_range(0, 5) == 0) rsp_hold = pick_gap();
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("camera_bus_command_sender_tb: done, errors");
         $finish;
      end
   end

   initial begin
      cfg_type c;
      int      n;
      bit      first;
      first = 1'b1;
      repeat (3) @(posedge clock);
      reset     <= 1'b0;
      send_idle = 1'b1;
      rsp_idle  = 1'b1;
      for (int i = 0; i < 3; i++)
         send_tick(StartRows[i].cmd, StartRows[i].mode, StartRows[i].command,
                   StartRows[i].line, StartRows[i].known, StartRows[i].res);
      drain();
      load_config('{10'd0, 16'd0, 4'd0, 1'b1});
      for (int i = 3; i < 13; i++)
         send_tick(StartRows[i].cmd, StartRows[i].mode, StartRows[i].command,
                   StartRows[i].line, StartRows[i].known, StartRows[i].res);
      wind_down();
      drain();

      while (sent_count < TotalItems) begin
         if (first) begin
            c = '{10'd1, 16'd3, 4'd15, 1'b1};
            first = 1'b0;
         end else begin
            n = $urandom_range(0, 9);
            c.bit_ticks    = (n < 7) ? 10'(n) : 10'($urandom_range(8, 12));
            c.sync_ticks   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3))
                                                         : 16'($urandom_range(4, 40));
            c.repeat_limit = 4'($urandom_range(0, 15));
            c.link_present = ($urandom_range(0, 5) != 0);
         end
         load_config(c);
         send_idle = ($urandom_range(0, 3) != 0);
         rsp_idle  = ($urandom_range(0, 3) != 0);
         n = $urandom_range(200, 400);
         for (int k = 0; k < n && sent_count < TotalItems; k++) begin
            random_tick();
            if (k == n / 2) drain();
         end
         wind_down();
         drain();
      end
      repeat (DrainCycles) @(posedge clock);
      if (errors == 0)
         $display("camera_bus_command_sender_tb: done, clean");
      else
         $display("camera_bus_command_sender_tb: done, errors");
      $finish;
   end

endmodule
